// ----- src/hztd_pkg.sv -----
// ----------------------------------------------------------------------------
// hztd_pkg
// Shared types, codes and byte classes for the HZ text decoder.
// ----------------------------------------------------------------------------
package hztd_pkg;

	localparam logic [7:0] CH_TILDE       = 8'h7E;
	localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
	localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
	localparam logic [7:0] CH_NEWLINE     = 8'h0A;
	localparam logic [7:0] HIGH_BIT_MASK  = 8'h80;
	localparam logic [7:0] LOW_SEVEN_MASK = 8'h7F;

	// Decoder mode, one-hot.
	typedef enum logic [5:0] {
		MODE_ASCII    = 6'b000001,
		MODE_TILDE    = 6'b000010,
		MODE_TILDE_GB = 6'b000100,
		MODE_GB       = 6'b001000,
		MODE_GB1      = 6'b010000,
		MODE_GR1      = 6'b100000
	} mode_t;

	// Token kinds as seen on the output tuser field.
	typedef enum logic [2:0] {
		KIND_ASCII = 3'd0,
		KIND_GB    = 3'd1,
		KIND_UNK1  = 3'd2,
		KIND_UNK2  = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [15:0] value;
	} token_t;

	// Graphic byte of the left half.
	function automatic logic is_gl(input logic [7:0] b);
		return (b >= 8'h21) && (b <= 8'h7E);
	endfunction

	// Graphic byte of the right half.
	function automatic logic is_gr(input logic [7:0] b);
		return (b >= 8'hA1) && (b <= 8'hFE);
	endfunction

endpackage

// ----- src/hztd_decode.sv -----
// ----------------------------------------------------------------------------
// hztd_decode
// Next-state and token logic for one byte of HZ text.
// ----------------------------------------------------------------------------
module hztd_decode (
	input  hztd_pkg::mode_t  mode,
	input  logic [7:0]       prev_byte,
	input  logic [7:0]       data_byte,
	input  logic             end_of_text,
	output hztd_pkg::mode_t  mode_next,
	output logic [7:0]       prev_next,
	output hztd_pkg::token_t tok
);

	logic [15:0]      pair;
	logic [7:0]       low7;
	hztd_pkg::mode_t  m;
	hztd_pkg::token_t t;
	logic             pending;

	assign pair = {prev_byte, data_byte};
	assign low7 = data_byte & hztd_pkg::LOW_SEVEN_MASK;

	always_comb begin
		m = mode;
		t = '{valid: 1'b0, kind: hztd_pkg::KIND_END, value: 16'd0};
		unique case (mode)
			hztd_pkg::MODE_TILDE: begin
				if (data_byte == hztd_pkg::CH_OPEN_BRACE) begin
					m = hztd_pkg::MODE_GB;
				end else begin
					if (data_byte == hztd_pkg::CH_TILDE) begin
						t = '{valid: 1'b1, kind: hztd_pkg::KIND_ASCII,
						      value: {8'd0, data_byte}};
					end else if (data_byte != hztd_pkg::CH_NEWLINE) begin
						t = '{valid: 1'b1, kind: hztd_pkg::KIND_UNK2, value: pair};
					end
					m = hztd_pkg::MODE_ASCII;
				end
			end
			hztd_pkg::MODE_TILDE_GB: begin
				if (data_byte == hztd_pkg::CH_CLOSE_BRACE ||
				    data_byte == hztd_pkg::CH_NEWLINE) begin
					m = hztd_pkg::MODE_ASCII;
				end else begin
					t = '{valid: 1'b1,
					      kind: hztd_pkg::is_gl(low7) ? hztd_pkg::KIND_GB
					                                  : hztd_pkg::KIND_UNK2,
					      value: pair};
					m = hztd_pkg::MODE_GB;
				end
			end
			hztd_pkg::MODE_GB: begin
				if (data_byte == hztd_pkg::CH_TILDE) begin
					m = hztd_pkg::MODE_TILDE_GB;
				end else if (hztd_pkg::is_gl(low7)) begin
					m = hztd_pkg::MODE_GB1;
				end else begin
					t = '{valid: 1'b1, kind: hztd_pkg::KIND_UNK1,
					      value: {8'd0, data_byte}};
				end
			end
			hztd_pkg::MODE_GB1: begin
				t = '{valid: 1'b1,
				      kind: hztd_pkg::is_gl(low7) ? hztd_pkg::KIND_GB
				                                  : hztd_pkg::KIND_UNK2,
				      value: pair};
				m = hztd_pkg::MODE_GB;
			end
			hztd_pkg::MODE_GR1: begin
				t = '{valid: 1'b1,
				      kind: hztd_pkg::is_gr(data_byte) ? hztd_pkg::KIND_GB
				                                       : hztd_pkg::KIND_UNK2,
				      value: pair};
				m = hztd_pkg::MODE_ASCII;
			end
			default: begin
				// ASCII idle; any other code behaves the same way.
				if (data_byte == hztd_pkg::CH_TILDE) begin
					m = hztd_pkg::MODE_TILDE;
				end else if (hztd_pkg::is_gr(data_byte)) begin
					m = hztd_pkg::MODE_GR1;
				end else if ((data_byte & hztd_pkg::HIGH_BIT_MASK) != 8'd0) begin
					t = '{valid: 1'b1, kind: hztd_pkg::KIND_UNK1,
					      value: {8'd0, data_byte}};
				end else begin
					t = '{valid: 1'b1, kind: hztd_pkg::KIND_ASCII,
					      value: {8'd0, data_byte}};
				end
			end
		endcase
	end

	// A byte that leaves a partial sequence never makes a token itself, so
	// the end of text flush never competes with one.
	assign pending = (m == hztd_pkg::MODE_TILDE) || (m == hztd_pkg::MODE_TILDE_GB) ||
	                 (m == hztd_pkg::MODE_GB1)   || (m == hztd_pkg::MODE_GR1);

	always_comb begin
		tok       = t;
		mode_next = m;
		prev_next = data_byte;
		if (end_of_text) begin
			if (pending) begin
				tok = '{valid: 1'b1, kind: hztd_pkg::KIND_UNK1,
				        value: {8'd0, data_byte}};
			end else if (!t.valid) begin
				tok = '{valid: 1'b1, kind: hztd_pkg::KIND_END, value: 16'd0};
			end
			mode_next = hztd_pkg::MODE_ASCII;
			prev_next = 8'd0;
		end
	end

endmodule

// ----- src/hz_text_decoder.sv -----
// ----------------------------------------------------------------------------
// hz_text_decoder
// Decodes an HZ encoded byte stream into ASCII, GB 2312 and unknown tokens.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                 Contents
// s_*       in         tvalid tready tdata     tdata[7:0] data_byte
//                      tlast                   tlast end_of_text
// m_*       out        tvalid tready tdata     tdata[15:0] token_value
//                      tuser tlast             tuser[2:0] token_kind,
//                                              tlast last_of_run
//
// One byte is taken per cycle while the skid register is not full. Each byte
// makes zero or one token, registered in the result register, or in the skid
// register behind a stalled token. The decode is a single pass of logic from
// the mode and previous-byte registers into the result register. The two-entry
// output buffer lets a byte be taken in the same cycle that a waiting token is
// stalled; s_tready falls only while the skid register is full. Reset puts the
// decoder in ASCII mode with a zero previous byte and empties the buffer.
// ----------------------------------------------------------------------------
module hz_text_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] token_value
	output logic [2:0]  m_tuser,   // [2:0] token_kind
	output logic        m_tlast    // last_of_run
);

	// Decoder state: current mode and the byte before the current one.
	hztd_pkg::mode_t  mode_q;
	logic [7:0]       prev_q;

	hztd_pkg::mode_t  mode_next;
	logic [7:0]       prev_next;
	hztd_pkg::token_t tok;

	// Result register and skid register.
	hztd_pkg::token_t out_q;
	hztd_pkg::token_t skid_q;

	logic accept;
	logic push;
	logic pop;

	hztd_decode u_decode (
		.mode        (mode_q),
		.prev_byte   (prev_q),
		.data_byte   (s_tdata),
		.end_of_text (s_tlast),
		.mode_next   (mode_next),
		.prev_next   (prev_next),
		.tok         (tok)
	);

	// The skid register is the only thing that can block the input.
	assign s_tready = !skid_q.valid;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && tok.valid;
	assign pop      = out_q.valid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hztd_pkg::MODE_ASCII;
			prev_q <= 8'd0;
		end else if (accept) begin
			mode_q <= mode_next;
			prev_q <= prev_next;
		end
	end

	// When the result register frees up, the skid entry moves first; the
	// input is held off while the skid is full, so no new token arrives then.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else begin
			if (!out_q.valid || pop) begin
				if (skid_q.valid) begin
					out_q        <= skid_q;
					skid_q.valid <= 1'b0;
				end else begin
					out_q.valid <= push;
					if (push) begin
						out_q.kind  <= tok.kind;
						out_q.value <= tok.value;
					end
				end
			end else if (push) begin
				skid_q <= tok;
			end
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = out_q.value;
	assign m_tuser  = out_q.kind;
	// A byte never makes more than one token, so every token closes its run.
	assign m_tlast  = 1'b1;

	// The skid register only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q.valid |-> out_q.valid)
		else $error("skid entry held with an empty result register");

	// The final byte of a text always makes a token.
	a_end_makes_token: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |-> tok.valid)
		else $error("end of text byte made no token");

	// After the final byte the decoder is ready for a fresh text.
	a_end_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (mode_q == hztd_pkg::MODE_ASCII && prev_q == 8'd0))
		else $error("state not cleared after end of text");

	// A stalled result with a full skid must not be overwritten.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_q.valid && !m_tready && skid_q.valid) |=>
		(out_q.valid && skid_q.valid && $stable(out_q.value)))
		else $error("buffered token lost during stall");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HZ text decoder. Byte streams go in as
// directed texts and then as random texts that are built mostly from valid
// HZ sequences, with noise and truncated sequences mixed in. A scoreboard
// predicts every token and compares each output transfer field by field
// against the oldest prediction. The sender runs in bursts and the receiver
// stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1900;

	typedef struct {
		hztd_pkg::kind_t kind;
		logic [15:0]     value;
		logic            last;
	} expected_token_t;

	// Tracks the decoder state and the queue of tokens still to arrive.
	class token_scoreboard;
		hztd_pkg::mode_t mode = hztd_pkg::MODE_ASCII;
		logic [7:0]      prev_byte = 8'h00;
		expected_token_t expected_q[$];
		expected_token_t staged[$];
		int              errors = 0;
		int              checked = 0;
		int              kind_seen[5] = '{default: 0};

		function automatic logic left_graphic(logic [7:0] b);
			return b >= 8'h21 && b <= 8'h7E;
		endfunction

		function automatic logic right_graphic(logic [7:0] b);
			return b >= 8'hA1 && b <= 8'hFE;
		endfunction

		function void emit(hztd_pkg::kind_t k, logic [15:0] v);
			expected_token_t t;
			t.kind = k;
			t.value = v;
			t.last = 1'b0;
			staged.push_back(t);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Called for every accepted byte; queues the tokens it must cause.
		function void note_input(logic [7:0] b, logic eot);
			logic [15:0]     pair;
			hztd_pkg::mode_t nxt;
			logic [7:0]      low7;
			pair = {prev_byte, b};
			low7 = b & hztd_pkg::LOW_SEVEN_MASK;
			nxt = mode;
			case (mode)
				hztd_pkg::MODE_TILDE: begin
					if (b == hztd_pkg::CH_OPEN_BRACE) begin
						nxt = hztd_pkg::MODE_GB;
					end else begin
						if (b == hztd_pkg::CH_TILDE) begin
							emit(hztd_pkg::KIND_ASCII, {8'h00, b});
						end else if (b != hztd_pkg::CH_NEWLINE) begin
							emit(hztd_pkg::KIND_UNK2, pair);
						end
						nxt = hztd_pkg::MODE_ASCII;
					end
				end
				hztd_pkg::MODE_TILDE_GB: begin
					if (b == hztd_pkg::CH_CLOSE_BRACE || b == hztd_pkg::CH_NEWLINE) begin
						nxt = hztd_pkg::MODE_ASCII;
					end else begin
						if (left_graphic(low7)) emit(hztd_pkg::KIND_GB, pair);
						else emit(hztd_pkg::KIND_UNK2, pair);
						nxt = hztd_pkg::MODE_GB;
					end
				end
				hztd_pkg::MODE_GB: begin
					if (b == hztd_pkg::CH_TILDE) nxt = hztd_pkg::MODE_TILDE_GB;
					else if (left_graphic(low7)) nxt = hztd_pkg::MODE_GB1;
					else emit(hztd_pkg::KIND_UNK1, {8'h00, b});
				end
				hztd_pkg::MODE_GB1: begin
					if (left_graphic(low7)) emit(hztd_pkg::KIND_GB, pair);
					else emit(hztd_pkg::KIND_UNK2, pair);
					nxt = hztd_pkg::MODE_GB;
				end
				hztd_pkg::MODE_GR1: begin
					if (right_graphic(b)) emit(hztd_pkg::KIND_GB, pair);
					else emit(hztd_pkg::KIND_UNK2, pair);
					nxt = hztd_pkg::MODE_ASCII;
				end
				default: begin
					if (b == hztd_pkg::CH_TILDE) nxt = hztd_pkg::MODE_TILDE;
					else if (right_graphic(b)) nxt = hztd_pkg::MODE_GR1;
					else if ((b & hztd_pkg::HIGH_BIT_MASK) != 8'h00)
						emit(hztd_pkg::KIND_UNK1, {8'h00, b});
					else emit(hztd_pkg::KIND_ASCII, {8'h00, b});
				end
			endcase
			prev_byte = b;
			mode = nxt;
			if (eot) begin
				// A sequence cut off by the end of text is flushed as its last byte.
				if (nxt inside {hztd_pkg::MODE_TILDE, hztd_pkg::MODE_TILDE_GB,
				                hztd_pkg::MODE_GB1, hztd_pkg::MODE_GR1})
					emit(hztd_pkg::KIND_UNK1, {8'h00, b});
				if (staged.size() == 0) emit(hztd_pkg::KIND_END, 16'h0000);
				mode = hztd_pkg::MODE_ASCII;
				prev_byte = 8'h00;
			end
			if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
			foreach (staged[i]) expected_q.push_back(staged[i]);
			staged.delete();
		endfunction

		function void check_token(logic [2:0] kind, logic [15:0] value, logic last);
			expected_token_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: unexpected token, expected none, %s %0d value %h last %b",
						$time, "actual kind", kind, value, last);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (kind < 5) kind_seen[kind]++;
			if (kind !== e.kind || value !== e.value || last !== e.last) begin
				errors++;
				if (errors <= 20) begin
					if (kind !== e.kind)
						$display("%0t: token_kind expected %0d actual %0d", $time, e.kind, kind);
					if (value !== e.value)
						$display("%0t: token_value expected %h actual %h", $time, e.value, value);
					if (last !== e.last)
						$display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	token_scoreboard sb = new();

	int         burst_left = 0;
	int         bytes_sent = 0;
	int         texts_sent = 0;
	int         ready_style = 0;
	int         style_left = 0;
	int         cycle_count = 0;
	logic [7:0] text_q[$];

	// Directed texts: bit 8 marks the end of text.
	logic [8:0] directed_q[$] = '{
		{1'b0, 8'h00}, {1'b0, 8'hFF},                         // low extreme, high-bit unknown
		{1'b0, 8'hA1}, {1'b0, 8'hFE},                         // bare GR pair
		{1'b0, 8'hFE}, {1'b0, 8'h41},                         // GR then non-GR
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, hztd_pkg::CH_TILDE}, // literal tilde
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, 8'h78},            // tilde with other byte
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, hztd_pkg::CH_OPEN_BRACE}, // enter GB
		{1'b0, 8'h21}, {1'b0, 8'h7E},                         // GB code at both GL range ends
		{1'b0, 8'h20},                                        // non-GL alone in GB
		{1'b0, 8'hA1}, {1'b0, 8'h00},                         // GB first byte, bad second
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, 8'h30},            // tilde with GL in GB
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, 8'h80},            // tilde with non-GL in GB
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, hztd_pkg::CH_NEWLINE}, // tilde newline leaves GB
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, hztd_pkg::CH_OPEN_BRACE},
		{1'b0, hztd_pkg::CH_TILDE}, {1'b0, hztd_pkg::CH_CLOSE_BRACE}, // leave GB
		{1'b0, hztd_pkg::CH_TILDE}, {1'b1, hztd_pkg::CH_NEWLINE}, // ends with only an end token
		{1'b1, 8'hC0}                                         // ends inside a GR pair
	};

	hz_text_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: checks every output transfer and changes its stall pattern now and then.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && m_tvalid && m_tready) sb.check_token(m_tuser, m_tdata, m_tlast);
		if (style_left == 0) begin
			ready_style = $urandom_range(0, 3);
			style_left = $urandom_range(20, 200);
		end else begin
			style_left--;
		end
		case (ready_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycle_count % 7) >= 3);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		sb.note_input(b, eot);
		bytes_sent++;
		if (eot) texts_sent++;
		burst_left--;
	endtask

	// Holds the sender off until every predicted token has been seen.
	task automatic drain_tokens();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] rand_gl();
		return 8'($urandom_range(8'h21, 8'h7D));
	endfunction

	function automatic logic [7:0] rand_gb_byte();
		return rand_gl() | ($urandom_range(0, 1) ? hztd_pkg::HIGH_BIT_MASK : 8'h00);
	endfunction

	function automatic logic [7:0] rand_ascii();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 127)); while (b == hztd_pkg::CH_TILDE);
		return b;
	endfunction

	// Builds one text, mostly well-formed HZ with some noise and broken sequences.
	task automatic build_text();
		int pick;
		int cut;
		text_q.delete();
		repeat ($urandom_range(1, 12)) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				text_q.push_back(rand_ascii());
			end else if (pick < 38) begin
				text_q.push_back(hztd_pkg::CH_TILDE);
				text_q.push_back(hztd_pkg::CH_TILDE);
			end else if (pick < 58) begin
				text_q.push_back(hztd_pkg::CH_TILDE);
				text_q.push_back(hztd_pkg::CH_OPEN_BRACE);
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 4) == 0) text_q.push_back(hztd_pkg::CH_TILDE);
					else text_q.push_back(rand_gb_byte());
					text_q.push_back(rand_gb_byte());
				end
				text_q.push_back(hztd_pkg::CH_TILDE);
				text_q.push_back(($urandom_range(0, 9) < 7) ? hztd_pkg::CH_CLOSE_BRACE
					: hztd_pkg::CH_NEWLINE);
			end else if (pick < 68) begin
				text_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
				text_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
			end else if (pick < 74) begin
				text_q.push_back(hztd_pkg::CH_TILDE);
				text_q.push_back(hztd_pkg::CH_NEWLINE);
			end else if (pick < 88) begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: text_q.push_back(hztd_pkg::CH_TILDE);
					1: text_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
					default: begin
						text_q.push_back(hztd_pkg::CH_TILDE);
						text_q.push_back(hztd_pkg::CH_OPEN_BRACE);
						text_q.push_back(rand_gb_byte());
					end
				endcase
				text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		// Cutting the text short leaves sequences open at the end of text.
		if ($urandom_range(0, 3) == 0) begin
			cut = $urandom_range(1, text_q.size());
			while (text_q.size() > cut) void'(text_q.pop_back());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
		drain_tokens();

		while (bytes_sent < RANDOM_BYTES + directed_q.size()) begin
			build_text();
			foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
			if ($urandom_range(0, 15) == 0) drain_tokens();
		end

		drain_tokens();
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d texts, checked %0d tokens", bytes_sent, texts_sent,
			sb.checked);
		$display("Token kinds seen: ascii %0d, gb %0d, unknown1 %0d, unknown2 %0d, end %0d",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d tokens outstanding", sb.pending());
		$display("tb NOT OK");
		$finish;
	end

endmodule
